@@ rtl/core/quaternion_slerp_core_macros.svh @@
// Assertion macros shared by the quaternion slerp core.
`ifndef QUATERNION_SLERP_CORE_MACROS_SVH
`define QUATERNION_SLERP_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quaternion slerp core check failed");

// The consequent must hold in the cycle after the antecedent.
`define QS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quaternion slerp core check failed");

`endif

@@ rtl/core/qslerp_pkg.sv @@
// Types, constants and the arctangent table of the quaternion slerp core.
package qslerp_pkg;

   localparam int COMP_W = 16;
   localparam int LANES = 4;
   localparam int PROD_W = 32;
   localparam int DOT_W = 34;
   localparam int MAG28_W = 28;
   localparam int SQ_W = 56;
   localparam int S2_W = 57;
   localparam int ROOT_W = 29;
   localparam int CORDIC_W = 34;
   localparam int CORDIC_ITERS = 28;
   localparam int SIN_W = 32;
   localparam int PART_W = 48;
   localparam int NUM_W = 49;
   localparam int MAG_W = 48;
   localparam int DIV_W = 31;
   localparam int QUO_BITS = 15;
   localparam int ANG_PROD_W = 52;
   localparam int ANG_SHIFT = 15;

   localparam int LAT_MERGE = 3;
   localparam int LAT_OUT = QUO_BITS + 4;

   localparam int ST_IN = 0;
   localparam int ST_PROD = ST_IN + 1;
   localparam int ST_FLAGS = ST_PROD + LAT_MERGE;
   localparam int ST_ROOT = ST_FLAGS + ROOT_W;
   localparam int ST_ATAN = ST_ROOT + CORDIC_ITERS;
   localparam int ST_THETA = ST_ATAN + 1;
   localparam int ST_PHI = ST_THETA + 1;
   localparam int ST_FOLD = ST_PHI + 1;
   localparam int ST_SIN = ST_FOLD + CORDIC_ITERS;
   localparam int ST_LAST = ST_SIN + LAT_OUT;

   localparam logic signed [DOT_W-1:0] ONE_Q28 = 34'sd268435456;
   localparam logic signed [CORDIC_W-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [CORDIC_W-1:0] GAIN_INV_Q30 = 34'sd652032874;
   localparam logic [S2_W-1:0] ONE_Q56 = 57'h100_0000_0000_0000;
   localparam logic [S2_W-1:0] TINY_SIN_SQ_Q56 = 57'd72057594037;
   localparam logic [COMP_W-1:0] BLEND_ONE = 16'd32768;
   localparam logic [COMP_W-1:0] SAT_POS = 16'h7fff;
   localparam logic [COMP_W-1:0] SAT_NEG = 16'h8000;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef prod_type prod_vec_type [LANES];
   typedef logic signed [CORDIC_W-1:0] cordic_word_type;

   typedef enum logic {
      CORDIC_VECTOR,
      CORDIC_ROTATE
   } cordic_mode_type;

   typedef enum logic [1:0] {
      PATH_FULL = 2'd0,
      PATH_FIRST = 2'd1,
      PATH_AVG = 2'd2
   } path_type;

   typedef struct packed {
      logic [LANES-1:0][COMP_W-1:0] a;
      logic [LANES-1:0][COMP_W-1:0] b;
      logic [COMP_W-1:0] t;
      logic signed [DOT_W-1:0] c;
      path_type path;
      logic [ROOT_W-1:0] s;
   } side_type;

   typedef struct packed {
      logic [LANES-1:0][COMP_W-1:0] r;
      path_type path;
   } result_type;

   function automatic cordic_word_type atan_q30(input int i);
      cordic_word_type r;
      case (i)
         0: r = 34'sd843314856;
         1: r = 34'sd497837829;
         2: r = 34'sd263043836;
         3: r = 34'sd133525158;
         4: r = 34'sd67021686;
         5: r = 34'sd33543515;
         6: r = 34'sd16775850;
         7: r = 34'sd8388437;
         8: r = 34'sd4194282;
         9: r = 34'sd2097149;
         default: r = (CORDIC_W'(1) << (30 - i)) - CORDIC_W'(1);
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/qslerp_dot_lane.sv @@
// One lane of the dot product: a registered product of two components.
module qslerp_dot_lane
   import qslerp_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [COMP_W-1:0] a,
   input  logic signed [COMP_W-1:0] b,
   output prod_type                 prod_ff
);

   prod_type prod_in;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

@@ rtl/core/qslerp_merge.sv @@
// Merging stage: sums the lane products and classifies the interpolation path.
module qslerp_merge
   import qslerp_pkg::*;
(
   input  logic                    clock,
   input  logic                    en,
   input  prod_vec_type            prod,
   output logic signed [DOT_W-1:0] c_ff,
   output logic [S2_W-1:0]         s2_ff,
   output path_type                path_ff
);

   logic signed [DOT_W-1:0] dot_ff;
   logic signed [DOT_W-1:0] dot_in;
   logic signed [DOT_W-1:0] dot2_ff;
   logic signed [DOT_W-1:0] neg_dot;
   logic [MAG28_W-1:0]      mag_in;
   logic                    big_in;
   logic                    big_ff;
   logic [SQ_W-1:0]         csq_ff;
   logic [S2_W-1:0]         s2_in;
   path_type                path_in;

   assign dot_in = DOT_W'(prod[0]) + DOT_W'(prod[1]) + DOT_W'(prod[2]) + DOT_W'(prod[3]);
   assign neg_dot = -dot_ff;
   assign mag_in = dot_ff[DOT_W-1] ? neg_dot[MAG28_W-1:0] : dot_ff[MAG28_W-1:0];
   assign big_in = (dot_ff >= ONE_Q28) || (dot_ff <= -ONE_Q28);
   assign s2_in = ONE_Q56 - {1'b0, csq_ff};

   always_comb begin
      if (big_ff) begin
         path_in = PATH_FIRST;
      end else if (s2_in <= TINY_SIN_SQ_Q56) begin
         path_in = PATH_AVG;
      end else begin
         path_in = PATH_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dot_ff <= dot_in;
         big_ff <= big_in;
         csq_ff <= mag_in * mag_in;
         dot2_ff <= dot_ff;
         c_ff <= dot2_ff;
         s2_ff <= s2_in;
         path_ff <= path_in;
      end
   end

endmodule

@@ rtl/core/qslerp_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module qslerp_sqrt
   import qslerp_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [S2_W-1:0]   v,
   output logic [ROOT_W-1:0] root
);

   localparam int TW = S2_W + 3;

   logic [TW-1:0]     rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      localparam int K = ROOT_W - 1 - g;
      logic [TW-1:0]     rem_prev;
      logic [TW-1:0]     trial;
      logic [ROOT_W-1:0] root_prev;

      if (g == 0) begin : g_first
         assign rem_prev = TW'(v);
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
      end

      assign trial = (TW'(root_prev) << (K + 1)) | (TW'(1) << (2 * K));

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_prev >= trial) begin
               rem_ff[g] <= rem_prev - trial;
               root_ff[g] <= root_prev | (ROOT_W'(1) << K);
            end else begin
               rem_ff[g] <= rem_prev;
               root_ff[g] <= root_prev;
            end
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

@@ rtl/core/qslerp_cordic.sv @@
// Pipelined shift-and-add CORDIC in vectoring or rotation mode.
module qslerp_cordic
   import qslerp_pkg::*;
(
   input  logic            clock,
   input  logic            en,
   input  cordic_mode_type mode,
   input  cordic_word_type x_in,
   input  cordic_word_type y_in,
   input  cordic_word_type z_in,
   output cordic_word_type y_out,
   output cordic_word_type z_out
);

   cordic_word_type x_ff [CORDIC_ITERS];
   cordic_word_type y_ff [CORDIC_ITERS];
   cordic_word_type z_ff [CORDIC_ITERS];

   for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_stage
      localparam cordic_word_type ATAN = atan_q30(g);
      cordic_word_type x_prev;
      cordic_word_type y_prev;
      cordic_word_type z_prev;
      cordic_word_type dx;
      cordic_word_type dy;
      logic            rot_pos;

      if (g == 0) begin : g_first
         assign x_prev = x_in;
         assign y_prev = y_in;
         assign z_prev = z_in;
      end else begin : g_next
         assign x_prev = x_ff[g-1];
         assign y_prev = y_ff[g-1];
         assign z_prev = z_ff[g-1];
      end

      assign dx = y_prev >>> g;
      assign dy = x_prev >>> g;
      assign rot_pos = (mode == CORDIC_VECTOR) ? !(y_prev > 0) : (z_prev >= 0);

      always_ff @(posedge clock) begin
         if (en) begin
            if (rot_pos) begin
               x_ff[g] <= x_prev - dx;
               y_ff[g] <= y_prev + dy;
               z_ff[g] <= z_prev - ATAN;
            end else begin
               x_ff[g] <= x_prev + dx;
               y_ff[g] <= y_prev - dy;
               z_ff[g] <= z_prev + ATAN;
            end
         end
      end
   end

   assign y_out = y_ff[CORDIC_ITERS-1];
   assign z_out = z_ff[CORDIC_ITERS-1];

endmodule

@@ rtl/core/qslerp_out_lane.sv @@
// One output lane: weighted sum, division by four times the sine, saturation.
module qslerp_out_lane
   import qslerp_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  cordic_word_type          sin_a,
   input  cordic_word_type          sin_b,
   input  logic signed [COMP_W-1:0] a,
   input  logic signed [COMP_W-1:0] b,
   input  logic [ROOT_W-1:0]        s,
   output logic [COMP_W-1:0]        r_ff
);

   logic signed [SIN_W-1:0]  sa;
   logic signed [SIN_W-1:0]  sb;
   logic signed [PART_W-1:0] pa_in;
   logic signed [PART_W-1:0] pb_in;
   logic signed [PART_W-1:0] pa_ff;
   logic signed [PART_W-1:0] pb_ff;
   logic [ROOT_W-1:0]        s1_ff;
   logic signed [NUM_W-1:0]  num;
   logic signed [NUM_W-1:0]  neg_num;
   logic [MAG_W-1:0]         mag_ff;
   logic                     neg2_ff;
   logic [DIV_W-1:0]         d2_ff;
   logic [MAG_W-1:0]         rem0_ff;
   logic                     neg3_ff;
   logic                     ovf3_ff;
   logic [DIV_W-1:0]         d3_ff;
   logic [MAG_W-1:0]         rem_ff [QUO_BITS];
   logic [QUO_BITS-1:0]      q_ff   [QUO_BITS];
   logic [DIV_W-1:0]         d_ff   [QUO_BITS];
   logic                     neg_ff [QUO_BITS];
   logic                     ovf_ff [QUO_BITS];
   logic [COMP_W-1:0]        q_ext;
   logic [COMP_W-1:0]        r_in;

   assign sa = sin_a[SIN_W-1:0];
   assign sb = sin_b[SIN_W-1:0];
   assign pa_in = sa * a;
   assign pb_in = sb * b;
   assign num = NUM_W'(pa_ff) + NUM_W'(pb_ff);
   assign neg_num = -num;

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         s1_ff <= s;
         neg2_ff <= num[NUM_W-1];
         mag_ff <= num[NUM_W-1] ? neg_num[MAG_W-1:0] : num[MAG_W-1:0];
         d2_ff <= {s1_ff, 2'b00};
         rem0_ff <= mag_ff;
         neg3_ff <= neg2_ff;
         ovf3_ff <= mag_ff >= (MAG_W'(d2_ff) << QUO_BITS);
         d3_ff <= d2_ff;
      end
   end

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
      localparam int K = QUO_BITS - 1 - g;
      logic [MAG_W-1:0]    rem_prev;
      logic [MAG_W-1:0]    trial;
      logic [QUO_BITS-1:0] q_prev;
      logic [DIV_W-1:0]    d_prev;
      logic                neg_prev;
      logic                ovf_prev;

      if (g == 0) begin : g_first
         assign rem_prev = rem0_ff;
         assign q_prev = '0;
         assign d_prev = d3_ff;
         assign neg_prev = neg3_ff;
         assign ovf_prev = ovf3_ff;
      end else begin : g_next
         assign rem_prev = rem_ff[g-1];
         assign q_prev = q_ff[g-1];
         assign d_prev = d_ff[g-1];
         assign neg_prev = neg_ff[g-1];
         assign ovf_prev = ovf_ff[g-1];
      end

      assign trial = MAG_W'(d_prev) << K;

      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[g] <= d_prev;
            neg_ff[g] <= neg_prev;
            ovf_ff[g] <= ovf_prev;
            if (rem_prev >= trial) begin
               rem_ff[g] <= rem_prev - trial;
               q_ff[g] <= q_prev | (QUO_BITS'(1) << K);
            end else begin
               rem_ff[g] <= rem_prev;
               q_ff[g] <= q_prev;
            end
         end
      end
   end

   assign q_ext = {1'b0, q_ff[QUO_BITS-1]};

   always_comb begin
      if (ovf_ff[QUO_BITS-1]) begin
         r_in = neg_ff[QUO_BITS-1] ? SAT_NEG : SAT_POS;
      end else begin
         r_in = neg_ff[QUO_BITS-1] ? -q_ext : q_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
      end
   end

endmodule

@@ rtl/core/quaternion_slerp_core.sv @@
// Top level of the quaternion slerp core: lanes, merge, root, angles and output.
//
// Usage: the request channel carries two quaternions (signed Q1.14) and a
// blend factor (unsigned Q1.15, values above one are treated as one). A
// transfer happens when req_valid is high and req_stall is low. The response
// channel returns the interpolated quaternion and the path code with the same
// valid and stall rule; rsp_stall is driven by the receiver.
// Throughput is one transfer per cycle while req_stall is low. The pipeline
// contains the 29 stage square root, two 28 stage CORDIC passes in series
// (angle, then both sines side by side) and the 15 stage divider in each
// output lane.
// While a response is stalled the pipeline keeps moving and taking requests
// until the next valid result reaches its end; that result moves into a skid
// register. With the skid register full, req_stall rises and the whole
// pipeline holds until the receiver takes a transfer.
// The synchronous reset empties the pipeline and both output registers.
`include "quaternion_slerp_core_macros.svh"

module quaternion_slerp_core
   import qslerp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [COMP_W-1:0] req_a_x,
   input  logic signed [COMP_W-1:0] req_a_y,
   input  logic signed [COMP_W-1:0] req_a_z,
   input  logic signed [COMP_W-1:0] req_a_w,
   input  logic signed [COMP_W-1:0] req_b_x,
   input  logic signed [COMP_W-1:0] req_b_y,
   input  logic signed [COMP_W-1:0] req_b_z,
   input  logic signed [COMP_W-1:0] req_b_w,
   input  logic [COMP_W-1:0]        req_blend,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [COMP_W-1:0] rsp_r_x,
   output logic signed [COMP_W-1:0] rsp_r_y,
   output logic signed [COMP_W-1:0] rsp_r_z,
   output logic signed [COMP_W-1:0] rsp_r_w,
   output logic [1:0]               rsp_path
);

   logic                    adv;
   logic [ST_LAST:0]        vld_ff;
   side_type                side_ff [ST_LAST+1];
   side_type                side_in [ST_LAST+1];
   prod_vec_type            prod;
   logic signed [DOT_W-1:0] merge_c;
   logic [S2_W-1:0]         merge_s2;
   path_type                merge_path;
   logic [ROOT_W-1:0]       root;
   cordic_word_type         atan_x;
   cordic_word_type         atan_z;
   cordic_word_type         theta_ff;
   cordic_word_type         phia_ff;
   cordic_word_type         phib_ff;
   cordic_word_type         folda_ff;
   cordic_word_type         foldb_ff;
   cordic_word_type         sin_a;
   cordic_word_type         sin_b;
   logic [COMP_W:0]         wa;
   logic signed [ANG_PROD_W-1:0] pha_prod;
   logic signed [ANG_PROD_W-1:0] phb_prod;
   logic [COMP_W-1:0]       lane_r [LANES];
   result_type              pd;
   result_type              rsp_ff;
   result_type              skid_ff;
   logic                    rsp_v_ff;
   logic                    skid_v_ff;

   assign adv = !skid_v_ff;
   assign req_stall = skid_v_ff;

   always_comb begin
      side_in[0].a = {req_a_w, req_a_z, req_a_y, req_a_x};
      side_in[0].b = {req_b_w, req_b_z, req_b_y, req_b_x};
      side_in[0].t = (req_blend > BLEND_ONE) ? BLEND_ONE : req_blend;
      side_in[0].c = '0;
      side_in[0].path = PATH_FULL;
      side_in[0].s = '0;
      for (int k = 1; k <= ST_LAST; k++) begin
         side_in[k] = side_ff[k-1];
         if (k == ST_FLAGS + 1) begin
            side_in[k].c = merge_c;
            side_in[k].path = merge_path;
         end
         if (k == ST_ROOT + 1) begin
            side_in[k].s = root;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ST_LAST-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= ST_LAST; k++) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_dot
      qslerp_dot_lane u_dot (
         .clock   (clock),
         .en      (adv),
         .a       ($signed(side_ff[ST_IN].a[i])),
         .b       ($signed(side_ff[ST_IN].b[i])),
         .prod_ff (prod[i])
      );
   end

   qslerp_merge u_merge (
      .clock   (clock),
      .en      (adv),
      .prod    (prod),
      .c_ff    (merge_c),
      .s2_ff   (merge_s2),
      .path_ff (merge_path)
   );

   qslerp_sqrt u_sqrt (
      .clock (clock),
      .en    (adv),
      .v     (merge_s2),
      .root  (root)
   );

   assign atan_x = side_ff[ST_ROOT].c[DOT_W-1] ? -side_ff[ST_ROOT].c : side_ff[ST_ROOT].c;

   qslerp_cordic u_atan (
      .clock (clock),
      .en    (adv),
      .mode  (CORDIC_VECTOR),
      .x_in  (atan_x),
      .y_in  (CORDIC_W'(root)),
      .z_in  ('0),
      .y_out (),
      .z_out (atan_z)
   );

   assign wa = {1'b0, BLEND_ONE} - {1'b0, side_ff[ST_THETA].t};
   assign pha_prod = theta_ff * $signed({1'b0, wa});
   assign phb_prod = theta_ff * $signed({2'b00, side_ff[ST_THETA].t});

   always_ff @(posedge clock) begin
      if (adv) begin
         theta_ff <= side_ff[ST_ATAN].c[DOT_W-1] ? PI_Q30 - atan_z : atan_z;
         phia_ff <= CORDIC_W'(pha_prod >>> ANG_SHIFT);
         phib_ff <= CORDIC_W'(phb_prod >>> ANG_SHIFT);
         folda_ff <= (phia_ff > HALF_PI_Q30) ? PI_Q30 - phia_ff : phia_ff;
         foldb_ff <= (phib_ff > HALF_PI_Q30) ? PI_Q30 - phib_ff : phib_ff;
      end
   end

   qslerp_cordic u_sin_a (
      .clock (clock),
      .en    (adv),
      .mode  (CORDIC_ROTATE),
      .x_in  (GAIN_INV_Q30),
      .y_in  ('0),
      .z_in  (folda_ff),
      .y_out (sin_a),
      .z_out ()
   );

   qslerp_cordic u_sin_b (
      .clock (clock),
      .en    (adv),
      .mode  (CORDIC_ROTATE),
      .x_in  (GAIN_INV_Q30),
      .y_in  ('0),
      .z_in  (foldb_ff),
      .y_out (sin_b),
      .z_out ()
   );

   for (genvar i = 0; i < LANES; i++) begin : g_out
      qslerp_out_lane u_out (
         .clock (clock),
         .en    (adv),
         .sin_a (sin_a),
         .sin_b (sin_b),
         .a     ($signed(side_ff[ST_SIN].a[i])),
         .b     ($signed(side_ff[ST_SIN].b[i])),
         .s     (side_ff[ST_SIN].s),
         .r_ff  (lane_r[i])
      );
   end

   always_comb begin
      logic [COMP_W:0] sum;
      pd.path = side_ff[ST_LAST].path;
      for (int i = 0; i < LANES; i++) begin
         sum = {side_ff[ST_LAST].a[i][COMP_W-1], side_ff[ST_LAST].a[i]}
             + {side_ff[ST_LAST].b[i][COMP_W-1], side_ff[ST_LAST].b[i]};
         case (side_ff[ST_LAST].path)
            PATH_FIRST: pd.r[i] = side_ff[ST_LAST].a[i];
            PATH_AVG: pd.r[i] = sum[COMP_W:1];
            default: pd.r[i] = lane_r[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!rsp_v_ff || !rsp_stall) begin
         if (skid_v_ff) begin
            rsp_v_ff <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            rsp_v_ff <= vld_ff[ST_LAST];
         end
      end else if (vld_ff[ST_LAST] && adv) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_v_ff || !rsp_stall) begin
         rsp_ff <= skid_v_ff ? skid_ff : pd;
      end else if (vld_ff[ST_LAST] && adv) begin
         skid_ff <= pd;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_r_x = rsp_ff.r[0];
   assign rsp_r_y = rsp_ff.r[1];
   assign rsp_r_z = rsp_ff.r[2];
   assign rsp_r_w = rsp_ff.r[3];
   assign rsp_path = rsp_ff.path;

   `QS_ASSERT_IMP(a_skid_behind_rsp, clock, reset, skid_v_ff, rsp_v_ff)
   `QS_ASSERT_NXT(a_skid_fills, clock, reset, rsp_v_ff && rsp_stall && !skid_v_ff && vld_ff[ST_LAST], skid_v_ff)
   `QS_ASSERT_NXT(a_skid_drains, clock, reset, skid_v_ff && !rsp_stall, rsp_v_ff && !skid_v_ff)

endmodule

@@ test/quaternion_slerp_core_tb.sv @@
// Self-checking testbench for the quaternion slerp core with a fixed-point predictor.
`timescale 1ns / 1ps

module quaternion_slerp_core_tb;
   import qslerp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic signed [15:0] r [4];
      path_type path;
   } slerp_result_type;

   typedef struct {
      logic signed [15:0] a [4];
      logic signed [15:0] b [4];
      logic [15:0] blend;
   } slerp_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_a_x = '0, req_a_y = '0, req_a_z = '0, req_a_w = '0;
   logic signed [15:0] req_b_x = '0, req_b_y = '0, req_b_z = '0, req_b_w = '0;
   logic [15:0] req_blend = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w;
   logic [1:0] rsp_path;

   slerp_result_type expected_results [$];
   int error_count = 0;
   int idle_cycles = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   bit hold_receiver = 1'b0;

   quaternion_slerp_core DUT (.*);

   always #6 clock = ~clock;

   function automatic longint floor_shift(longint v, int n);
      if (v >= 0) return v >>> n;
      return -(((-v) - 1) >>> n) - 1;
   endfunction

   function automatic longint arctan_entry(int i);
      longint table_low [10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                                 33543515, 16775850, 8388437, 4194282, 2097149};
      if (i < 10) return table_low[i];
      return (longint'(1) << (30 - i)) - 1;
   endfunction

   function automatic longint root_floor(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned bitv = longint'(1) << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vector_angle(longint x, longint y);
      longint z = 0;
      longint dx, dy;
      for (int i = 0; i < 28; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += arctan_entry(i);
         end else begin
            x -= dx; y += dy; z -= arctan_entry(i);
         end
      end
      return z;
   endfunction

   function automatic longint rotate_sine(longint phi);
      longint x = 652032874;
      longint y = 0;
      longint z, dx, dy;
      if (phi > 1686629713) phi = 64'sd3373259426 - phi;
      z = phi;
      for (int i = 0; i < 28; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_entry(i);
         end else begin
            x += dx; y -= dy; z += arctan_entry(i);
         end
      end
      return y;
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic slerp_result_type predict_slerp(slerp_request_type q);
      slerp_result_type res;
      longint dot = 0;
      longint t, s, theta, sin_a, sin_b, num;
      longint unsigned s2;
      for (int i = 0; i < 4; i++) dot += longint'(q.a[i]) * longint'(q.b[i]);
      t = q.blend;
      if (t > 32768) t = 32768;
      if (dot >= (longint'(1) << 28) || dot <= -(longint'(1) << 28)) begin
         foreach (res.r[i]) res.r[i] = q.a[i];
         res.path = PATH_FIRST;
         return res;
      end
      s2 = (longint'(1) << 56) - dot * dot;
      if (s2 <= 64'd72057594037) begin
         foreach (res.r[i]) res.r[i] = clamp16(floor_shift(longint'(q.a[i]) + q.b[i], 1));
         res.path = PATH_AVG;
         return res;
      end
      s = root_floor(s2);
      if (dot >= 0) theta = vector_angle(dot, s);
      else theta = 64'sd3373259426 - vector_angle(-dot, s);
      sin_a = rotate_sine(((32768 - t) * theta) >>> 15);
      sin_b = rotate_sine((t * theta) >>> 15);
      for (int i = 0; i < 4; i++) begin
         num = sin_a * q.a[i] + sin_b * q.b[i];
         res.r[i] = clamp16(num / (4 * s));
      end
      res.path = PATH_FULL;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic send_request(slerp_request_type q);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_a_x, req_a_y, req_a_z, req_a_w} <= {q.a[0], q.a[1], q.a[2], q.a[3]};
      {req_b_x, req_b_y, req_b_z, req_b_w} <= {q.b[0], q.b[1], q.b[2], q.b[3]};
      req_blend <= q.blend;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(predict_slerp(q));
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      end_burst();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic slerp_request_type make_request(logic [15:0] ax, logic [15:0] ay,
         logic [15:0] az, logic [15:0] aw, logic [15:0] bx, logic [15:0] by,
         logic [15:0] bz, logic [15:0] bw, logic [15:0] blend);
      slerp_request_type q;
      q.a = '{ax, ay, az, aw};
      q.b = '{bx, by, bz, bw};
      q.blend = blend;
      return q;
   endfunction

   function automatic logic [15:0] random_unit_part();
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   // A random pair, mostly with components in the unit range, with b optionally near a or -a for the tiny-angle path.
   function automatic slerp_request_type random_request();
      slerp_request_type q;
      int kind = $urandom_range(9);
      for (int i = 0; i < 4; i++) begin
         q.a[i] = (kind == 0) ? 16'($urandom) : random_unit_part() >>> $urandom_range(1);
         q.b[i] = (kind == 0) ? 16'($urandom) : random_unit_part() >>> $urandom_range(1);
      end
      if (kind == 1 || kind == 2) begin
         q.a = '{16'sd16384, 0, 0, 0};
         q.b = '{16'(16384 - $urandom_range(kind == 1 ? 3 : 200)),
                 16'($signed($urandom_range(40)) - 20), 0, 0};
         if ($urandom_range(1)) q.b[0] = -q.b[0];
      end
      if (kind == 3) q.b = q.a;
      q.blend = (kind == 4) ? 16'($urandom) : 16'($urandom_range(32768));
      return q;
   endfunction

   task automatic test_directed();
      logic [15:0] one = 16'sd16384;
      send_request(make_request(one, 0, 0, 0, one, 0, 0, 0, 16'd16384));
      send_request(make_request(one, 0, 0, 0, -one, 0, 0, 0, 16'd0));
      send_request(make_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff));
      send_request(make_request(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'd32768));
      send_request(make_request(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd1));
      send_request(make_request(one, 0, 0, 0, 0, one, 0, 0, 16'd0));
      send_request(make_request(one, 0, 0, 0, 0, one, 0, 0, 16'd32768));
      send_request(make_request(one, 0, 0, 0, 0, one, 0, 0, 16'd16384));
      send_request(make_request(one, 0, 0, 0, 0, one, 0, 0, 16'd40000));
      send_request(make_request(0, 0, 0, one, 0, 0, 0, -one, 16'd8192));
      send_request(make_request(one, 0, 0, 0, 16'sd16383, 16'sd1, 0, 0, 16'd20000));
      send_request(make_request(one, 0, 0, 0, -16'sd16383, 16'sd5, 0, 0, 16'd20000));
      send_request(make_request(one, 0, 0, 0, 16'sd16300, 16'sd1600, 0, 0, 16'd12345));
      send_request(make_request(16'sd11585, 16'sd11585, 0, 0, 0, 0, 16'sd11585,
                                16'sd11585, 16'd32767));
      send_request(make_request(16'sd9000, -16'sd9000, 16'sd9000, -16'sd9000,
                                -16'sd5000, 16'sd12000, 16'sd3000, 16'sd7000, 16'd100));
      send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
      wait_drained();
   endtask

   task automatic test_random(int count);
      repeat (count) send_request(random_request());
      wait_drained();
   endtask

   // The receiver holds off while requests keep coming, then starts taking transfers again.
   task automatic test_backpressure();
      fork
         begin
            hold_receiver = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_receiver = 1'b0;
         end
      join_none
      repeat (200) send_request(random_request());
      wait_drained();
   endtask

   // Response side: stall generation and the result check.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_receiver || (receiver_idle_pct > 0 &&
                      $urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      slerp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_path, -1);
         end else begin
            want = expected_results.pop_front();
            if (rsp_r_x !== want.r[0]) report_mismatch("r_x", rsp_r_x, want.r[0]);
            if (rsp_r_y !== want.r[1]) report_mismatch("r_y", rsp_r_y, want.r[1]);
            if (rsp_r_z !== want.r[2]) report_mismatch("r_z", rsp_r_z, want.r[2]);
            if (rsp_r_w !== want.r[3]) report_mismatch("r_w", rsp_r_w, want.r[3]);
            if (rsp_path !== want.path) report_mismatch("path", rsp_path, want.path);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      sender_idle_pct = 30;
      receiver_idle_pct = 83;
      test_random(400);
      sender_idle_pct = 83;
      receiver_idle_pct = 30;
      test_random(400);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_backpressure();
      test_random(230);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
